### rtl/vo3_pkg.sv
package vo3_pkg;

  // input beat: normal and tangent, signed fixed point
  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
  } in_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic               was_degenerate;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } clamp_t;

  localparam logic signed [65:0] CLAMP_MAX = 66'sd2147483647;
  localparam logic signed [65:0] CLAMP_MIN = -CLAMP_MAX - 66'sd1;

  // sign extend a 64-bit product to the wide working width
  function automatic logic signed [65:0] sx64(input logic signed [63:0] v);
    return {{2{v[63]}}, v};
  endfunction

  function automatic logic signed [65:0] sx32(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  // clamp to the signed 32-bit range
  function automatic clamp_t clamp32(input logic signed [65:0] v);
    clamp_t c;
    if (v > CLAMP_MAX) begin
      c.sat = 1'b1;
      c.val = 32'sh7fffffff;
    end else if (v < CLAMP_MIN) begin
      c.sat = 1'b1;
      c.val = 32'sh80000000;
    end else begin
      c.sat = 1'b0;
      c.val = v[31:0];
    end
    return c;
  endfunction

endpackage

### rtl/vector3_orthonormalize.sv
// gram-schmidt orthonormalization of a tangent against a normal, signed fixed point
//
// input channel: in_valid / in_stall carry one beat of normal and tangent vectors
// (in_data); a beat is taken at a clock edge with in_valid high and in_stall low.
// result channel: out_valid / out_stall carry the unit tangent plus the
// was_degenerate and saturated flags (out_data).
//
// throughput: one beat per cycle while the receiver does not stall.
// pipeline: six stages for the dot product, projection and squared length, 32 stages of
// the digit-by-digit square root (one root bit per stage), FRAC_BITS + 1 stages
// of the three restoring dividers (one quotient bit per stage), one stage for
// sign and zero handling, then the output register.
//
// reset clears every valid bit, including those of the output and skid stages.
// when the receiver stalls, the beat in flight out of the pipe lands in a skid
// register; in_stall is that skid's full flag, so the whole pipe freezes while the
// skid is full and nothing is dropped or repeated. in_stall is a register.
module vector3_orthonormalize #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  vo3_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output vo3_pkg::out_t  out_data
);
  import vo3_pkg::*;

  localparam int SQS = 32;            // square root stages, one root bit each
  localparam int DS  = FRAC_BITS + 1; // divider stages, one quotient bit each
  localparam int QW  = FRAC_BITS + 1; // quotient magnitude width, |r| <= sqrt

  logic en;               // global pipe advance
  logic skid_v_r;
  out_t skid_r;
  logic out_valid_r;
  out_t out_r;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  logic signed [31:0] nin [3];
  logic signed [31:0] tin [3];
  assign nin[0] = in_data.normal_x;
  assign nin[1] = in_data.normal_y;
  assign nin[2] = in_data.normal_z;
  assign tin[0] = in_data.tangent_x;
  assign tin[1] = in_data.tangent_y;
  assign tin[2] = in_data.tangent_z;

  // stage 1: tangent times normal, per lane
  logic               v1_r;
  logic signed [63:0] p1_r [3];
  logic signed [31:0] n1_r [3];
  logic signed [31:0] t1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= nin[i] * tin[i];
        n1_r[i] <= nin[i];
        t1_r[i] <= tin[i];
      end
    end
  end

  // stage 2: exact sum, floor shift, clamp gives the dot product
  logic signed [65:0] dsum;
  logic signed [65:0] dsh;
  clamp_t             dc;
  logic               v2_r;
  logic               sat2_r;
  logic signed [31:0] dot2_r;
  logic signed [31:0] n2_r [3];
  logic signed [31:0] t2_r [3];

  always_comb begin
    dsum = sx64(p1_r[0]) + sx64(p1_r[1]) + sx64(p1_r[2]);
    dsh  = dsum >>> FRAC_BITS;
    dc   = clamp32(dsh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      dot2_r <= dc.val;
      sat2_r <= dc.sat;
      for (int i = 0; i < 3; i++) begin
        n2_r[i] <= n1_r[i];
        t2_r[i] <= t1_r[i];
      end
    end
  end

  // stage 3: normal times dot
  logic               v3_r;
  logic               sat3_r;
  logic signed [63:0] p3_r [3];
  logic signed [31:0] t3_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      sat3_r <= sat2_r;
      for (int i = 0; i < 3; i++) begin
        p3_r[i] <= n2_r[i] * dot2_r;
        t3_r[i] <= t2_r[i];
      end
    end
  end

  // stage 4: projection and remainder, both clamped
  clamp_t             pc [3];
  clamp_t             rc [3];
  logic signed [65:0] dif [3];
  logic               sat4;
  logic               v4_r;
  logic               sat4_r;
  logic signed [31:0] r4_r [3];

  always_comb begin
    sat4 = sat3_r;
    for (int i = 0; i < 3; i++) begin
      pc[i]  = clamp32(sx64(p3_r[i]) >>> FRAC_BITS);
      dif[i] = sx32(t3_r[i]) - sx32(pc[i].val);
      rc[i]  = clamp32(dif[i]);
      sat4   = sat4 | pc[i].sat | rc[i].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      sat4_r <= sat4;
      for (int i = 0; i < 3; i++) begin
        r4_r[i] <= rc[i].val;
      end
    end
  end

  // stage 5: squares
  logic               v5_r;
  logic               sat5_r;
  logic signed [63:0] sqr5_r [3];
  logic signed [31:0] r5_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
    if (en) begin
      sat5_r <= sat4_r;
      for (int i = 0; i < 3; i++) begin
        sqr5_r[i] <= r4_r[i] * r4_r[i];
        r5_r[i]   <= r4_r[i];
      end
    end
  end

  // stage 6: squared length, at most 3 * 2^62 so no wrap
  logic               v6_r;
  logic               sat6_r;
  logic [63:0]        sq6_r;
  logic signed [31:0] r6_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
    if (en) begin
      sat6_r <= sat5_r;
      sq6_r  <= 64'(sqr5_r[0]) + 64'(sqr5_r[1]) + 64'(sqr5_r[2]);
      for (int i = 0; i < 3; i++) begin
        r6_r[i] <= r5_r[i];
      end
    end
  end

  // square root: two radicand bits per stage, root grows one bit per stage
  logic [33:0]        sr_rem_r [SQS];
  logic [31:0]        sr_q_r   [SQS];
  logic [63:0]        sr_x_r   [SQS];
  logic               sr_v_r   [SQS];
  logic               sr_sat_r [SQS];
  logic               sr_zero_r[SQS];
  logic signed [31:0] sr_r_r   [SQS][3];

  for (genvar k = 0; k < SQS; k++) begin : g_sqrt
    logic [33:0]        rin;
    logic [31:0]        qin;
    logic [63:0]        xin;
    logic               vin;
    logic               sin;
    logic               zin;
    logic signed [31:0] rvin [3];
    logic [35:0]        pre;
    logic [35:0]        trial;
    logic [35:0]        remn;
    logic               ge;

    if (k == 0) begin : g_head
      assign rin = '0;
      assign qin = '0;
      assign xin = sq6_r;
      assign vin = v6_r;
      assign sin = sat6_r;
      assign zin = (sq6_r == 64'd0);
      for (genvar i = 0; i < 3; i++) begin : g_ln
        assign rvin[i] = r6_r[i];
      end
    end else begin : g_body
      assign rin = sr_rem_r[k-1];
      assign qin = sr_q_r[k-1];
      assign xin = sr_x_r[k-1];
      assign vin = sr_v_r[k-1];
      assign sin = sr_sat_r[k-1];
      assign zin = sr_zero_r[k-1];
      for (genvar i = 0; i < 3; i++) begin : g_ln
        assign rvin[i] = sr_r_r[k-1][i];
      end
    end

    assign pre   = {rin, xin[63:62]};
    assign trial = {2'b00, qin, 2'b01};
    assign ge    = (pre >= trial);
    assign remn  = ge ? (pre - trial) : pre;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sr_v_r[k] <= 1'b0;
      end else if (en) begin
        sr_v_r[k] <= vin;
      end
      if (en) begin
        sr_rem_r[k]  <= remn[33:0];
        sr_q_r[k]    <= {qin[30:0], ge};
        sr_x_r[k]    <= {xin[61:0], 2'b00};
        sr_sat_r[k]  <= sin;
        sr_zero_r[k] <= zin;
        for (int i = 0; i < 3; i++) begin
          sr_r_r[k][i] <= rvin[i];
        end
      end
    end
  end

  // restoring dividers: |r| * 2^F / root, one quotient bit per stage, 3 lanes
  logic [32:0]   dv_rem_r [DS][3];
  logic [QW-1:0] dv_q_r   [DS][3];
  logic          dv_neg_r [DS][3];
  logic [31:0]   dv_s_r   [DS];
  logic          dv_v_r   [DS];
  logic          dv_sat_r [DS];
  logic          dv_zero_r[DS];

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [32:0]   rin  [3];
    logic [QW-1:0] qin  [3];
    logic          nin_s[3];
    logic [31:0]   sin;
    logic          vin;
    logic          satin;
    logic          zin;
    logic [32:0]   remn [3];
    logic          ge   [3];

    if (j == 0) begin : g_head
      assign sin   = sr_q_r[SQS-1];
      assign vin   = sr_v_r[SQS-1];
      assign satin = sr_sat_r[SQS-1];
      assign zin   = sr_zero_r[SQS-1];
      for (genvar i = 0; i < 3; i++) begin : g_ln
        logic [31:0] rv;
        assign rv       = sr_r_r[SQS-1][i];
        assign nin_s[i] = rv[31];
        assign rin[i]   = {1'b0, (rv[31] ? (~rv + 32'd1) : rv)};
        assign qin[i]   = '0;
      end
    end else begin : g_body
      assign sin   = dv_s_r[j-1];
      assign vin   = dv_v_r[j-1];
      assign satin = dv_sat_r[j-1];
      assign zin   = dv_zero_r[j-1];
      for (genvar i = 0; i < 3; i++) begin : g_ln
        assign nin_s[i] = dv_neg_r[j-1][i];
        assign rin[i]   = dv_rem_r[j-1][i];
        assign qin[i]   = dv_q_r[j-1][i];
      end
    end

    for (genvar i = 0; i < 3; i++) begin : g_step
      assign ge[i]   = (rin[i] >= {1'b0, sin});
      assign remn[i] = ge[i] ? (rin[i] - {1'b0, sin}) : rin[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (en) begin
        dv_v_r[j] <= vin;
      end
      if (en) begin
        dv_s_r[j]    <= sin;
        dv_sat_r[j]  <= satin;
        dv_zero_r[j] <= zin;
        for (int i = 0; i < 3; i++) begin
          // remainder stays below the root, so one shift fits
          dv_rem_r[j][i] <= {remn[i][31:0], 1'b0};
          dv_q_r[j][i]   <= {qin[i][QW-2:0], ge[i]};
          dv_neg_r[j][i] <= nin_s[i];
        end
      end
    end
  end

  // final stage: restore sign, zero vector passes through as zero
  logic [31:0] mag [3];
  logic [31:0] res [3];
  logic        fin_v_r;
  out_t        fin_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = 32'(dv_q_r[DS-1][i]);
      if (dv_zero_r[DS-1]) begin
        res[i] = '0;
      end else if (dv_neg_r[DS-1][i]) begin
        res[i] = ~mag[i] + 32'd1;
      end else begin
        res[i] = mag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= dv_v_r[DS-1];
    end
    if (en) begin
      fin_r.result_x       <= res[0];
      fin_r.result_y       <= res[1];
      fin_r.result_z       <= res[2];
      fin_r.was_degenerate <= dv_zero_r[DS-1];
      fin_r.saturated      <= dv_sat_r[DS-1];
    end
  end

  // output register with skid stage behind it
  logic take;
  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        out_r       <= skid_r;
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_r       <= fin_r;
      out_valid_r <= fin_v_r;
    end else if (fin_v_r) begin
      skid_r   <= fin_r;
      skid_v_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // skid only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid holds a beat while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without a stalled output beat");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.was_degenerate) |->
      (out_r.result_x == 32'sd0 && out_r.result_y == 32'sd0 &&
       out_r.result_z == 32'sd0))
    else $error("degenerate beat carries a nonzero vector");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import vo3_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 41;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // idle percentages for each side, changed between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // long receiver hold-off, counted down in its own process
  int unsigned hold_cycles = 0;

  out_t expected_vecs[$];
  int unsigned mismatches = 0;
  longint cycles = 0;

  always #4 clk = ~clk;

  vector3_orthonormalize #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // floor shift of a signed value
  function automatic logic signed [127:0] fshr(input logic signed [127:0] v);
    return v >>> FRAC;
  endfunction

  function automatic logic signed [127:0] sat32(input logic signed [127:0] v,
                                                inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 128'sd2147483647;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return -128'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] rem, res, bitv;
    rem = x;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // gram-schmidt prediction of one result beat
  function automatic out_t orthonormalize(input in_t v);
    logic signed [127:0] nv[3], tv[3], rv[3], dot, p, s, q;
    logic [127:0] sq;
    logic sat;
    out_t o;
    sat = 1'b0;
    nv[0] = v.normal_x; nv[1] = v.normal_y; nv[2] = v.normal_z;
    tv[0] = v.tangent_x; tv[1] = v.tangent_y; tv[2] = v.tangent_z;
    // exact sum then one floor, same as split whole/fraction sum
    dot = fshr(nv[0] * tv[0] + nv[1] * tv[1] + nv[2] * tv[2]);
    dot = sat32(dot, sat);
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      p = sat32(fshr(nv[i] * dot), sat);
      rv[i] = sat32(tv[i] - p, sat);
      sq += rv[i] * rv[i];
    end
    o = '0;
    if (sq == 0 || sq == (128'd1 << (2 * FRAC))) begin
      o.was_degenerate = (sq == 0);
      o.result_x = rv[0][31:0];
      o.result_y = rv[1][31:0];
      o.result_z = rv[2][31:0];
    end else begin
      s = $signed({64'd0, root64(sq[63:0])});
      // division truncates toward zero
      q = (rv[0] <<< FRAC) / s; o.result_x = 32'(sat32(q, sat));
      q = (rv[1] <<< FRAC) / s; o.result_y = 32'(sat32(q, sat));
      q = (rv[2] <<< FRAC) / s; o.result_z = 32'(sat32(q, sat));
    end
    o.saturated = sat;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // result checker: sample at the edge, compare with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vecs.size() == 0) begin
        report_mismatch("unexpected beat", out_data.result_x, 32'd0);
      end else begin
        want = expected_vecs.pop_front();
        if (out_data.result_x !== want.result_x)
          report_mismatch("result_x", out_data.result_x, want.result_x);
        if (out_data.result_y !== want.result_y)
          report_mismatch("result_y", out_data.result_y, want.result_y);
        if (out_data.result_z !== want.result_z)
          report_mismatch("result_z", out_data.result_z, want.result_z);
        if (out_data.was_degenerate !== want.was_degenerate)
          report_mismatch("was_degenerate", 32'(out_data.was_degenerate),
                          32'(want.was_degenerate));
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", 32'(out_data.saturated),
                          32'(want.saturated));
      end
    end
  end

  // receiver stall: long hold-off wins, otherwise random
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("vector3_orthonormalize verification failed");
      $finish;
    end
  end

  // send one beat, with a random gap before it; valid stays up back to back
  task automatic send_vec(input in_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_vecs.push_back(orthonormalize(v));
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom_range(3);
      2: return 32'h7fff_fff0 | $urandom_range(15);
      // small magnitudes around one in Q15.16
      3: return $signed($urandom_range(131072)) - 65536;
      4: return $signed($urandom_range(8192)) - 4096;
      default: return $signed($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  function automatic in_t make_vec(input logic [31:0] nx, ny, nz, tx, ty, tz);
    in_t v;
    v.normal_x = nx; v.normal_y = ny; v.normal_z = nz;
    v.tangent_x = tx; v.tangent_y = ty; v.tangent_z = tz;
    return v;
  endfunction

  function automatic in_t rnd_vec();
    in_t v;
    logic [31:0] one;
    one = 32'h0001_0000;
    v = make_vec(rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word());
    // well-formed pairs in about a third of the vectors: unit-axis normal, random tangent
    if ($urandom_range(2) == 0) begin
      v.normal_x = 0; v.normal_y = 0; v.normal_z = 0;
      case ($urandom_range(2))
        0: v.normal_x = $urandom_range(1) ? one : -one;
        1: v.normal_y = $urandom_range(1) ? one : -one;
        default: v.normal_z = $urandom_range(1) ? one : -one;
      endcase
    end
    return v;
  endfunction

  task automatic wait_drained();
    drop_valid();
    while (expected_vecs.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // extremes, unit length and zero remainder passthroughs, saturation
  task automatic test_directed();
    logic [31:0] one, mx, mn;
    one = 32'h0001_0000; mx = 32'h7fff_ffff; mn = 32'h8000_0000;
    send_vec(make_vec(0, 0, 0, 0, 0, 0));
    send_vec(make_vec(one, 0, 0, one, 0, 0));          // zero remainder
    send_vec(make_vec(one, 0, 0, 0, one, 0));          // unit length
    send_vec(make_vec(0, 0, one, 0, 0, -one));
    send_vec(make_vec(0, 0, one, one, one, 0));
    send_vec(make_vec(one, 0, 0, 5 * one, 3 * one, 4 * one));
    send_vec(make_vec(mx, mx, mx, mx, mx, mx));
    send_vec(make_vec(mn, mn, mn, mn, mn, mn));
    send_vec(make_vec(mx, mn, mx, mn, mx, mn));
    send_vec(make_vec(0, 0, 0, mx, mx, mx));
    send_vec(make_vec(0, 0, 0, mn, mn, mn));
    send_vec(make_vec(0, 0, 0, mn, 0, 0));
    send_vec(make_vec(0, 0, 0, 1, 0, 0));
    send_vec(make_vec(0, 0, 0, -1, -1, -1));
    send_vec(make_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1, 1));
    send_vec(make_vec(one, one, one, mx, mn, 0));
    send_vec(make_vec(32'h5555_5555, 32'haaaa_aaaa, 0, 32'haaaa_aaaa, 32'h5555_5555, 0));
    wait_drained();
  endtask

  task automatic test_random(input int n, input int unsigned send_pct,
                             input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      // stretches with no idling inside every phase
      if (i % 100 == 50) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (i % 100 == 80) begin
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
      end
      send_vec(rnd_vec());
    end
    wait_drained();
  endtask

  // hold the receiver off while the sender keeps offering
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 4 * LATENCY;
    for (int i = 0; i < 150; i++) send_vec(rnd_vec());
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300, 0, 0);
    test_random(300, 48, 0);
    test_random(300, 0, 48);
    test_random(300, 28, 28);
    test_backpressure();
    if (mismatches == 0) begin
      $display("vector3_orthonormalize verification clean");
    end else begin
      $display("vector3_orthonormalize verification failed");
    end
    $finish;
  end

endmodule
